FILE: sv/harmonic_tide_level_predictor_unit_macros.svh
// Assertion macros shared by the tide predictor RTL.
// Each macro expects clk_i and rst_ni in scope of the module that uses it.
`ifndef HARMONIC_TIDE_LEVEL_PREDICTOR_UNIT_MACROS_SVH
`define HARMONIC_TIDE_LEVEL_PREDICTOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HTLP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HTLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/htlp_pkg.sv
// Package for the tide level predictor: widths, payload types, register codes
// and the CORDIC arctangent table. Used by the divider, CORDIC and top-level RTL.
package htlp_pkg;

  localparam int TIME_W  = 48;
  localparam int CFG_W   = 32;
  localparam int PER_W   = 31;
  localparam int LVL_W   = 32;
  localparam int SWING_W = 17;
  localparam int DIFF_W  = 50;
  localparam int MAG_W   = 49;
  localparam int TURN_W  = 32;
  localparam int COS_W   = 32;
  localparam int ADDR_W  = 3;

  // Divider latency: magnitude stage, integer steps, sign fix, fraction steps.
  localparam int DIV_LAT = 1 + MAG_W + 1 + TURN_W;

  localparam logic [31:0] CORDIC_INV_GAIN = 32'd652032874;
  localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;

  typedef enum logic [ADDR_W-1:0] {
    CFG_MEAN_LEVEL     = 3'd0,
    CFG_MEAN_AMPLITUDE = 3'd1,
    CFG_SWING_PERIOD   = 3'd2,
    CFG_SWING_PHASE    = 3'd3,
    CFG_ENV_PERIOD     = 3'd4,
    CFG_ENV_RANGE      = 3'd5,
    CFG_ENV_PHASE      = 3'd6
  } htlp_cfg_e;

  typedef struct packed {
    logic signed [TIME_W-1:0] time_hours;
  } htlp_in_t;

  typedef struct packed {
    logic signed [LVL_W-1:0] water_level;
    logic [SWING_W-1:0]      normalized_swing;
    logic                    rising;
    logic [PER_W-1:0]        hours_to_high;
    logic [PER_W-1:0]        hours_to_low;
  } htlp_out_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [CFG_W-1:0]  wdata;
  } htlp_cfg_t;

  // Arctangent of 2^-i in Q2.30; exact table for the first steps, then 2^(30-i).
  function automatic logic [29:0] atan_step(input int unsigned i);
    logic [29:0] r;
    r = '0;
    case (i)
      0: r = 30'd843314857;
      1: r = 30'd497837829;
      2: r = 30'd263043837;
      3: r = 30'd133525159;
      4: r = 30'd67021687;
      5: r = 30'd33543516;
      6: r = 30'd16775851;
      7: r = 30'd8388437;
      8: r = 30'd4194283;
      9: r = 30'd2097149;
      default: begin
        if (i <= 30) r = 30'(64'd1 << (30 - i));
      end
    endcase
    return r;
  endfunction

endpackage

FILE: sv/htlp_chan_if.sv
// Valid/ready channel carrying one word of a payload type.
// Depends on nothing; payload types come from htlp_pkg at instantiation.
interface htlp_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/htlp_delay.sv
// Enable-gated shift line that keeps sideband data aligned with the pipeline.
// Depends on nothing outside this file.
module htlp_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [N];

  // Every tap moves one place per enabled cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) tap_q[k] <= '0;
    end else if (en_i) begin
      tap_q[0] <= d_i;
      for (int k = 1; k < N; k++) tap_q[k] <= tap_q[k-1];
    end
  end

  assign q_o = tap_q[N-1];

endmodule

FILE: sv/htlp_phase_div.sv
// Pipelined floor modulo and turn fraction: r = x mod p, turn = r*2^32/p.
// One restoring division step per stage; uses htlp_pkg widths.
module htlp_phase_div (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [htlp_pkg::DIFF_W-1:0] x_i,
  input  logic [htlp_pkg::PER_W-1:0]        period_i,
  output logic [htlp_pkg::PER_W-1:0]        rem_o,
  output logic [htlp_pkg::TURN_W-1:0]       turn_o
);

  localparam int MW = htlp_pkg::MAG_W;
  localparam int PW = htlp_pkg::PER_W;
  localparam int QW = htlp_pkg::TURN_W;

  logic [MW-1:0] mag_q  [MW+1];
  logic          neg_q  [MW+1];
  logic [PW-1:0] irem_q [MW+1];
  logic [PW-1:0] frem_q [QW+1];
  logic [PW-1:0] rr_q   [QW+1];
  logic [QW-1:0] quo_q  [QW+1];
  logic [PW:0]   per_ext;

  assign per_ext = {1'b0, period_i};

  // Split the difference into sign and magnitude.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q[0]  <= x_i[htlp_pkg::DIFF_W-1] ? MW'(-x_i) : MW'(x_i);
      neg_q[0]  <= x_i[htlp_pkg::DIFF_W-1];
      irem_q[0] <= '0;
    end
  end

  // Integer steps: bring in one magnitude bit, subtract the period when it fits.
  for (genvar j = 1; j <= MW; j++) begin : g_int
    logic [PW:0] trial;
    assign trial = {irem_q[j-1], mag_q[j-1][MW-j]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        irem_q[j] <= (trial >= per_ext) ? PW'(trial - per_ext) : trial[PW-1:0];
        mag_q[j]  <= mag_q[j-1];
        neg_q[j]  <= neg_q[j-1];
      end
    end
  end

  // A negative difference with a nonzero remainder wraps to the positive side.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (neg_q[MW] && (irem_q[MW] != '0)) begin
        frem_q[0] <= period_i - irem_q[MW];
        rr_q[0]   <= period_i - irem_q[MW];
      end else begin
        frem_q[0] <= irem_q[MW];
        rr_q[0]   <= irem_q[MW];
      end
      quo_q[0] <= '0;
    end
  end

  // Fraction steps: one quotient bit of r*2^32/p per stage.
  for (genvar j = 1; j <= QW; j++) begin : g_frac
    logic [PW:0] trial;
    logic        fits;
    assign trial = {frem_q[j-1], 1'b0};
    assign fits  = (trial >= per_ext);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        frem_q[j] <= fits ? PW'(trial - per_ext) : trial[PW-1:0];
        quo_q[j]  <= {quo_q[j-1][QW-2:0], fits};
        rr_q[j]   <= rr_q[j-1];
      end
    end
  end

  assign rem_o  = rr_q[QW];
  assign turn_o = quo_q[QW];

endmodule

FILE: sv/htlp_cordic.sv
// Pipelined CORDIC cosine of a Q0.32 turn fraction, Q2.30 result in [-1, 1].
// Quadrant fold, angle scaling, one rotation per stage, clamp; uses htlp_pkg.
module htlp_cordic #(
  parameter int STEPS = 18
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [htlp_pkg::TURN_W-1:0]       turn_i,
  output logic signed [htlp_pkg::COS_W-1:0] cos_o
);

  localparam int XW = 34;
  localparam logic signed [XW-1:0] ONE_Q30 = 34'sd1073741824;

  logic [32:0]          a_full;
  logic [32:0]          a_fold;
  logic                 fold_neg;
  logic [30:0]          fa_q;
  logic                 fneg_q;
  logic [61:0]          ang_prod;
  logic [61:0]          ang_rnd;
  logic signed [XW-1:0] x_q [STEPS+1];
  logic signed [XW-1:0] y_q [STEPS+1];
  logic signed [XW-1:0] z_q [STEPS+1];
  logic                 n_q [STEPS+1];
  logic signed [XW-1:0] xc;
  logic signed [htlp_pkg::COS_W-1:0] cos_q;

  // Fold the turn into the first quadrant, remembering the sign flip.
  always_comb begin
    a_full   = turn_i[31] ? (33'h1_0000_0000 - {1'b0, turn_i}) : {1'b0, turn_i};
    fold_neg = (a_full > 33'h0_4000_0000);
    a_fold   = fold_neg ? (33'h0_8000_0000 - a_full) : a_full;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fa_q   <= a_fold[30:0];
      fneg_q <= fold_neg;
    end
  end

  // Scale the turn fraction to a Q2.30 angle in radians.
  assign ang_prod = fa_q * htlp_pkg::HALF_PI_Q30;
  assign ang_rnd  = ang_prod + 62'd536870912;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= XW'(htlp_pkg::CORDIC_INV_GAIN);
      y_q[0] <= '0;
      z_q[0] <= XW'({1'b0, ang_rnd[61:30]});
      n_q[0] <= fneg_q;
    end
  end

  // Rotation steps toward zero residual angle.
  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    localparam logic signed [XW-1:0] ATAN = XW'(htlp_pkg::atan_step(i));
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - ATAN;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + ATAN;
        end
        n_q[i+1] <= n_q[i];
      end
    end
  end

  // Clamp to [-1, 1] and undo the fold.
  always_comb begin
    xc = x_q[STEPS];
    if (xc > ONE_Q30) xc = ONE_Q30;
    if (xc < -ONE_Q30) xc = -ONE_Q30;
    if (n_q[STEPS]) xc = -xc;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cos_q <= htlp_pkg::COS_W'(xc);
  end

  assign cos_o = cos_q;

endmodule

FILE: sv/harmonic_tide_level_predictor_unit.sv
// Harmonic tide level predictor, top level.
// Channels: time_i takes one word (time_hours, signed Q32.16 hours) per
// handshake; result_o gives one word per query with water_level,
// normalized_swing, rising, hours_to_high and hours_to_low; cfg_i writes one
// of the seven registers by index (index 7 is ignored), always ready.
// Throughput: one query per cycle while the skid register is empty. The
// pipeline depth is set by the six pipelined phase dividers (one quotient
// bit per stage over 49 integer and 32 fraction bits) followed by the
// CORDIC stages.
// Reset clears all words in flight and loads the register defaults
// (mean amplitude 1.0, swing period 12.42 h, everything else zero).
// When the receiver stalls, the output register holds its word and one more
// word lands in a skid register; time_i drops ready while the skid register
// is full, and the whole pipeline freezes without losing or repeating words.
// Registers must only be written while no query is in flight.
// Depends on htlp_pkg, htlp_chan_if, htlp_delay, htlp_phase_div, htlp_cordic.
`include "harmonic_tide_level_predictor_unit_macros.svh"

module harmonic_tide_level_predictor_unit #(
  parameter int CORDIC_STEPS = 18,
  parameter int FRAC_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  htlp_chan_if.sink   time_i,
  htlp_chan_if.source result_o,
  htlp_chan_if.sink   cfg_i
);

  localparam int CORD_LAT = CORDIC_STEPS + 3;
  localparam int POST_LAT = 4;
  localparam int PIPE_LAT = 1 + htlp_pkg::DIV_LAT + CORD_LAT + POST_LAT;
  localparam longint RISE_STEP  = ((64'sd1 << FRAC_BITS) + 500) / 1000;
  localparam longint ENV_EPS    = (64'sd1 << FRAC_BITS) / 10000;
  localparam longint SWING_RND  = 64'sd1 << (30 - FRAC_BITS);
  localparam int     SWING_SHR  = 31 - FRAC_BITS;
  localparam logic [htlp_pkg::SWING_W-1:0] SWING_HALF =
    htlp_pkg::SWING_W'(64'd1 << (FRAC_BITS - 1));

  // Configuration registers.
  logic signed [31:0] mean_level_q;
  logic signed [31:0] mean_amp_q;
  logic [30:0]        swing_period_q;
  logic signed [31:0] swing_phase_q;
  logic [30:0]        env_period_q;
  logic signed [31:0] env_range_q;
  logic signed [31:0] env_phase_q;

  logic en;
  logic pv;

  logic signed [49:0] t_pt [3];
  logic signed [49:0] xs_q [3];
  logic signed [49:0] xe_q [3];
  logic [31:0]        turn_sw  [3];
  logic [31:0]        turn_env [3];
  logic signed [31:0] cs [3];
  logic signed [31:0] ce [3];
  logic [30:0]        rem_sw0;
  logic [30:0]        rem_p4;

  logic signed [63:0] penv_q [3];
  logic signed [31:0] cs1_q  [3];
  logic [32:0]        env2_q [3];
  logic signed [31:0] cs2_q  [3];
  logic signed [65:0] plvl_q [3];
  logic [32:0]        env3_q;
  logic signed [31:0] c3_q;
  logic signed [35:0] lvl4_q [3];
  logic [htlp_pkg::SWING_W-1:0] swing4_q;

  logic signed [33:0] swing_sum;
  logic signed [33:0] swing_shr;
  logic signed [33:0] low_d;
  logic signed [33:0] low_sum;
  htlp_pkg::htlp_out_t pdata;
  htlp_pkg::htlp_out_t out_q;
  htlp_pkg::htlp_out_t skid_q;
  logic                out_v_q;
  logic                skid_v_q;
  logic                out_free;

  // Register writes; the port never stalls.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_level_q   <= '0;
      mean_amp_q     <= 32'sd65536;
      swing_period_q <= 31'd813957;
      swing_phase_q  <= '0;
      env_period_q   <= '0;
      env_range_q    <= '0;
      env_phase_q    <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.addr)
        htlp_pkg::CFG_MEAN_LEVEL:     mean_level_q   <= cfg_i.data.wdata;
        htlp_pkg::CFG_MEAN_AMPLITUDE: mean_amp_q     <= cfg_i.data.wdata;
        htlp_pkg::CFG_SWING_PERIOD:   swing_period_q <= cfg_i.data.wdata[30:0];
        htlp_pkg::CFG_SWING_PHASE:    swing_phase_q  <= cfg_i.data.wdata;
        htlp_pkg::CFG_ENV_PERIOD:     env_period_q   <= cfg_i.data.wdata[30:0];
        htlp_pkg::CFG_ENV_RANGE:      env_range_q    <= cfg_i.data.wdata;
        htlp_pkg::CFG_ENV_PHASE:      env_phase_q    <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  // The pipeline advances unless a word is parked in the skid register.
  assign en           = !skid_v_q;
  assign time_i.ready = en;

  // Query points t, t + step and t - step, relative to both phase origins.
  always_comb begin
    t_pt[0] = 50'(time_i.data.time_hours);
    t_pt[1] = t_pt[0] + 50'(RISE_STEP);
    t_pt[2] = t_pt[0] - 50'(RISE_STEP);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        xs_q[k] <= t_pt[k] - 50'(swing_phase_q);
        xe_q[k] <= t_pt[k] - 50'(env_phase_q);
      end
    end
  end

  // Phase dividers and cosine units, one pair per query point and tide term.
  for (genvar k = 0; k < 3; k++) begin : g_lane
    if (k == 0) begin : g_rem
      htlp_phase_div u_div_sw (
        .clk_i    (clk_i),
        .en_i     (en),
        .x_i      (xs_q[k]),
        .period_i (swing_period_q),
        .rem_o    (rem_sw0),
        .turn_o   (turn_sw[k])
      );
    end else begin : g_norem
      htlp_phase_div u_div_sw (
        .clk_i    (clk_i),
        .en_i     (en),
        .x_i      (xs_q[k]),
        .period_i (swing_period_q),
        .rem_o    (),
        .turn_o   (turn_sw[k])
      );
    end

    htlp_phase_div u_div_env (
      .clk_i    (clk_i),
      .en_i     (en),
      .x_i      (xe_q[k]),
      .period_i (env_period_q),
      .rem_o    (),
      .turn_o   (turn_env[k])
    );

    htlp_cordic #(.STEPS(CORDIC_STEPS)) u_cos_sw (
      .clk_i  (clk_i),
      .en_i   (en),
      .turn_i (turn_sw[k]),
      .cos_o  (cs[k])
    );

    htlp_cordic #(.STEPS(CORDIC_STEPS)) u_cos_env (
      .clk_i  (clk_i),
      .en_i   (en),
      .turn_i (turn_env[k]),
      .cos_o  (ce[k])
    );
  end

  // Swing remainder of the main point, carried past the cosine and level stages.
  htlp_delay #(.W(31), .N(CORD_LAT + POST_LAT)) u_rem_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    (rem_sw0),
    .q_o    (rem_p4)
  );

  // Word valid bit, aligned with the last level stage.
  htlp_delay #(.W(1), .N(PIPE_LAT)) u_vld_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    (time_i.valid),
    .q_o    (pv)
  );

  // Envelope product, envelope clamp, level product, level sum.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        penv_q[k] <= env_range_q * ce[k];
        cs1_q[k]  <= cs[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [63:0] rnd;
    logic signed [34:0] e;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        rnd = (penv_q[k] + 64'sd536870912) >>> 30;
        e   = 35'(mean_amp_q) + 35'(rnd);
        if (env_period_q == '0) begin
          env2_q[k] <= (mean_amp_q > 0) ? 33'(mean_amp_q) : '0;
        end else begin
          env2_q[k] <= (e > 0) ? 33'(e) : '0;
        end
        cs2_q[k] <= cs1_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        plvl_q[k] <= $signed({1'b0, env2_q[k]}) * cs2_q[k];
      end
      env3_q <= env2_q[0];
      c3_q   <= cs2_q[0];
    end
  end

  // Swing position (cos + 1) / 2 with rounding.
  always_comb begin
    swing_sum = 34'(c3_q) + 34'sd1073741824 + 34'(SWING_RND);
    swing_shr = swing_sum >>> SWING_SHR;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        lvl4_q[k] <= 36'(mean_level_q) + 36'((plvl_q[k] + 66'sd536870912) >>> 30);
      end
      swing4_q <= (env3_q <= 33'(ENV_EPS)) ? SWING_HALF : swing_shr[htlp_pkg::SWING_W-1:0];
    end
  end

  // Result word: saturation, slope, and waits to the next high and low; fixed values when the swing period is zero.
  always_comb begin
    low_d = 34'({2'b00, swing_period_q}) - 34'({1'b0, rem_p4, 1'b0});
    if (low_d <= 0) low_d = low_d + 34'({1'b0, swing_period_q, 1'b0});
    low_sum = (low_d + 34'sd1) >>> 1;

    if (swing_period_q == '0) begin
      pdata.water_level      = mean_level_q;
      pdata.normalized_swing = SWING_HALF;
      pdata.rising           = 1'b0;
      pdata.hours_to_high    = '0;
      pdata.hours_to_low     = '0;
    end else begin
      if (lvl4_q[0] > 36'sd2147483647) begin
        pdata.water_level = 32'sh7fffffff;
      end else if (lvl4_q[0] < -36'sd2147483648) begin
        pdata.water_level = 32'sh80000000;
      end else begin
        pdata.water_level = lvl4_q[0][31:0];
      end
      pdata.normalized_swing = swing4_q;
      pdata.rising           = (lvl4_q[1] > lvl4_q[2]);
      pdata.hours_to_high    = swing_period_q - rem_p4;
      pdata.hours_to_low     = low_sum[30:0];
    end
  end

  // Output register with a one-word skid register behind it.
  assign out_free = !out_v_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= pv;
      end
    end else if (pv && en) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_v_q ? skid_q : pdata;
    end else if (pv && en) begin
      skid_q <= pdata;
    end
  end

  assign result_o.valid = out_v_q;
  assign result_o.data  = out_q;

  `HTLP_ASSERT_NOW(a_skid_behind_out, skid_v_q, out_v_q, "skid word without an output word")
  `HTLP_ASSERT_NEXT(a_stall_fills_skid, pv && en && out_v_q && !result_o.ready, skid_v_q, "stalled word was not parked")
  `HTLP_ASSERT_NEXT(a_skid_drains, skid_v_q && result_o.ready, out_v_q && !skid_v_q, "skid word did not move to the output")

endmodule

FILE: tb/harmonic_tide_level_predictor_unit_tb_if.sv
// Channel instances for the tide predictor testbench are built from htlp_chan_if.
// This file holds the shared word types used by the testbench; it depends on htlp_pkg.
`timescale 1ns / 100ps
package htlp_tb_pkg;

  // One expected result word together with the query time that caused it.
  typedef struct {
    htlp_pkg::htlp_out_t word;
    logic signed [htlp_pkg::TIME_W-1:0] query;
  } tide_expect_t;
endpackage

FILE: tb/harmonic_tide_level_predictor_unit_tb.sv
// Testbench for harmonic_tide_level_predictor_unit: drives query times and register
// writes, predicts every result word with its own fixed-point model and checks it.
// Depends on htlp_pkg, htlp_chan_if, htlp_tb_pkg and the block's RTL.
`timescale 1ns / 100ps
module harmonic_tide_level_predictor_unit_tb;

  localparam int LATENCY = 110;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam longint ONE_Q30 = 64'sd1 << 30;
  localparam longint RISE_STEP = 66;
  localparam longint ENV_EPS = 6;

  logic clk_i;
  logic rst_ni;

  htlp_chan_if #(.T(htlp_pkg::htlp_in_t))  time_ch ();
  htlp_chan_if #(.T(htlp_pkg::htlp_out_t)) result_ch ();
  htlp_chan_if #(.T(htlp_pkg::htlp_cfg_t)) cfg_ch ();

  harmonic_tide_level_predictor_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .time_i  (time_ch.sink),
    .result_o(result_ch.source),
    .cfg_i   (cfg_ch.sink)
  );

  // Predictor copy of the registers.
  longint tide_mean;
  longint tide_amp;
  longint tide_period;
  longint tide_phase;
  longint env_period;
  longint env_range;
  longint env_phase;

  htlp_tb_pkg::tide_expect_t expected_words[$];
  int  error_count;
  int  idle_cycles;
  bit  rx_hold;
  bit  rx_burst;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Arithmetic shift right that rounds toward minus infinity.
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_q30(longint p);
    return shr_floor(p + (64'sd1 << 29), 30);
  endfunction

  function automatic longint atan_value(int i);
    longint table_head[10];
    table_head = '{843314857, 497837829, 263043837, 133525159, 67021687,
                   33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return table_head[i];
    if (i <= 30) return 64'sd1 << (30 - i);
    return 0;
  endfunction

  // Cosine of a Q0.32 turn fraction, Q2.30 result clamped to [-1, 1].
  function automatic longint cos_of_turn(longint unsigned u);
    longint unsigned a;
    bit     flip;
    longint x, y, z, dx, dy;
    a = u;
    flip = 1'b0;
    x = 652032874;
    y = 0;
    if (a >= (64'd1 << 31)) a = (64'd1 << 32) - a;
    if (a > (64'd1 << 30)) begin
      flip = 1'b1;
      a = (64'd1 << 31) - a;
    end
    z = longint'((a * 64'd1686629713 + (64'd1 << 29)) >> 30);
    for (int i = 0; i < 18; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_value(i);
      end else begin
        x += dx; y -= dy; z += atan_value(i);
      end
    end
    if (x > ONE_Q30) x = ONE_Q30;
    if (x < -ONE_Q30) x = -ONE_Q30;
    return flip ? -x : x;
  endfunction

  // Nonnegative remainder of (t - ref) by period and the matching turn fraction.
  function automatic longint unsigned turn_fraction(longint t, longint ref_hour,
                                                    longint period, output longint rem);
    longint r;
    longint unsigned ur;
    longint unsigned up;
    r = (t - ref_hour) % period;
    if (r < 0) r += period;
    rem = r;
    ur = unsigned'(r);
    up = unsigned'(period);
    return ((ur << 32) / up) & 64'hFFFF_FFFF;
  endfunction

  function automatic longint envelope_at(longint t);
    longint e, r;
    if (env_period == 0) return tide_amp > 0 ? tide_amp : 0;
    e = tide_amp + round_q30(env_range *
        cos_of_turn(turn_fraction(t, env_phase, env_period, r)));
    return e > 0 ? e : 0;
  endfunction

  function automatic longint level_at_time(longint t, output longint c,
                                           output longint env, output longint rem);
    c = cos_of_turn(turn_fraction(t, tide_phase, tide_period, rem));
    env = envelope_at(t);
    return tide_mean + round_q30(env * c);
  endfunction

  // Expected result word for one query time.
  function automatic htlp_pkg::htlp_out_t predict_tide(
      logic signed [htlp_pkg::TIME_W-1:0] query);
    htlp_pkg::htlp_out_t w;
    longint t, c, env, r, lvl, up, dn, c2, e2, r2, d;
    t = longint'(query);
    w = '0;
    if (tide_period == 0) begin
      w.water_level = tide_mean[31:0];
      w.normalized_swing = 17'd32768;
      return w;
    end
    lvl = level_at_time(t, c, env, r);
    up = level_at_time(t + RISE_STEP, c2, e2, r2);
    dn = level_at_time(t - RISE_STEP, c2, e2, r2);
    w.rising = up > dn;
    if (env <= ENV_EPS) w.normalized_swing = 17'd32768;
    else w.normalized_swing = 17'((c + ONE_Q30 + (64'sd1 << 14)) >>> 15);
    w.hours_to_high = 31'(tide_period - r);
    d = tide_period - 2 * r;
    if (d <= 0) d += 2 * tide_period;
    w.hours_to_low = 31'((d + 1) >>> 1);
    if (lvl > 64'sd2147483647) lvl = 64'sd2147483647;
    if (lvl < -64'sd2147483648) lvl = -64'sd2147483648;
    w.water_level = lvl[31:0];
    return w;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want, longint query);
    $display("MISMATCH %s: got %0d expected %0d (time %0d)", what, got, want, query);
    error_count++;
  endtask

  // Check every accepted result word against the oldest expectation.
  always @(posedge clk_i) begin
    htlp_tb_pkg::tide_expect_t e;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected result word", 1, 0, 0);
      end else begin
        e = expected_words.pop_front();
        if (result_ch.data.water_level !== e.word.water_level)
          report_mismatch("water_level", longint'(result_ch.data.water_level),
                          longint'(e.word.water_level), e.query);
        if (result_ch.data.normalized_swing !== e.word.normalized_swing)
          report_mismatch("normalized_swing", result_ch.data.normalized_swing,
                          e.word.normalized_swing, e.query);
        if (result_ch.data.rising !== e.word.rising)
          report_mismatch("rising", result_ch.data.rising, e.word.rising, e.query);
        if (result_ch.data.hours_to_high !== e.word.hours_to_high)
          report_mismatch("hours_to_high", result_ch.data.hours_to_high,
                          e.word.hours_to_high, e.query);
        if (result_ch.data.hours_to_low !== e.word.hours_to_low)
          report_mismatch("hours_to_low", result_ch.data.hours_to_low,
                          e.word.hours_to_low, e.query);
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk_i) begin
    if ((time_ch.valid && time_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver readiness: random stalls, a forced long hold, or full speed.
  always @(negedge clk_i) begin
    int g;
    if (rx_hold) begin
      result_ch.ready <= 1'b0;
    end else if (rx_burst) begin
      result_ch.ready <= 1'b1;
    end else begin
      g = gap_length();
      result_ch.ready <= (g == 0);
    end
  end

  // Send one query word and record its expected result; valid stays up so that
  // the next word can follow directly, and drops only across a gap.
  task automatic send_time(logic signed [htlp_pkg::TIME_W-1:0] query);
    htlp_tb_pkg::tide_expect_t e;
    int gap;
    gap = rx_burst ? 0 : gap_length();
    if (gap > 0) begin
      time_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    time_ch.valid <= 1'b1;
    time_ch.data.time_hours <= query;
    e.query = query;
    e.word = predict_tide(query);
    @(posedge clk_i);
    while (!time_ch.ready) @(posedge clk_i);
    expected_words.push_back(e);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    time_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Register write; only called once the pipeline is empty.
  task automatic write_reg(htlp_pkg::htlp_cfg_e index, logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data.addr <= index;
    cfg_ch.data.wdata <= value;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    case (index)
      htlp_pkg::CFG_MEAN_LEVEL:     tide_mean   = longint'(signed'(value));
      htlp_pkg::CFG_MEAN_AMPLITUDE: tide_amp    = longint'(signed'(value));
      htlp_pkg::CFG_SWING_PERIOD:   tide_period = longint'(value[30:0]);
      htlp_pkg::CFG_SWING_PHASE:    tide_phase  = longint'(signed'(value));
      htlp_pkg::CFG_ENV_PERIOD:     env_period  = longint'(value[30:0]);
      htlp_pkg::CFG_ENV_RANGE:      env_range   = longint'(signed'(value));
      htlp_pkg::CFG_ENV_PHASE:      env_phase   = longint'(signed'(value));
      default: ;
    endcase
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_all(logic [31:0] lvl, logic [31:0] amp, logic [31:0] per,
                           logic [31:0] ph, logic [31:0] eper, logic [31:0] erng,
                           logic [31:0] eph);
    write_reg(htlp_pkg::CFG_MEAN_LEVEL, lvl);
    write_reg(htlp_pkg::CFG_MEAN_AMPLITUDE, amp);
    write_reg(htlp_pkg::CFG_SWING_PERIOD, per);
    write_reg(htlp_pkg::CFG_SWING_PHASE, ph);
    write_reg(htlp_pkg::CFG_ENV_PERIOD, eper);
    write_reg(htlp_pkg::CFG_ENV_RANGE, erng);
    write_reg(htlp_pkg::CFG_ENV_PHASE, eph);
  endtask

  function automatic logic signed [htlp_pkg::TIME_W-1:0] random_time();
    case ($urandom_range(0, 3))
      0: return htlp_pkg::TIME_W'({$urandom(), $urandom()});
      1: return htlp_pkg::TIME_W'($signed($urandom_range(0, 32'h0400_0000)) -
                                  32'sh0200_0000);
      default: return htlp_pkg::TIME_W'(signed'($urandom()));
    endcase
  endfunction

  // Directed queries at the reset settings: field extremes, exact phases.
  task automatic test_reset_defaults();
    send_time('0);
    send_time({1'b0, {(htlp_pkg::TIME_W-1){1'b1}}});
    send_time({1'b1, {(htlp_pkg::TIME_W-1){1'b0}}});
    send_time(-48'sd1);
    send_time(48'sd1);
    send_time(48'sd813957);
    send_time(48'sd406978);
    send_time(48'sd406979);
    send_time(-48'sd813957);
    wait_drained();
  endtask

  // Swing disabled, envelope near zero, saturation and envelope modulation.
  task automatic test_special_settings();
    write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_time(48'sd12345);
    send_time({1'b1, {(htlp_pkg::TIME_W-1){1'b0}}});
    wait_drained();
    write_reg(htlp_pkg::CFG_SWING_PERIOD, 32'd813957);
    write_reg(htlp_pkg::CFG_MEAN_AMPLITUDE, 32'd6);
    send_time(48'sd1000);
    send_time(48'sd0);
    wait_drained();
    write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_time('0);
    send_time({1'b0, {(htlp_pkg::TIME_W-1){1'b1}}});
    send_time(-48'sd5);
    wait_drained();
    write_all(32'h8000_0000, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 32'd1,
              32'h7FFF_FFFF, 32'h8000_0000);
    send_time(48'sd7);
    send_time({1'b1, {(htlp_pkg::TIME_W-1){1'b0}}});
    wait_drained();
    write_all(32'd0, 32'd65536, 32'd813957, 32'd0, 32'd19353600, 32'd32768, 32'd0);
    send_time(48'sd0);
    send_time(48'sd9676800);
    wait_drained();
    // An index past the last register is ignored by the block.
    write_reg(htlp_pkg::htlp_cfg_e'(3'd7), 32'hFFFF_FFFF);
    send_time(48'sd100);
    wait_drained();
  endtask

  // Receiver holds off while queries keep coming, so the input stalls.
  task automatic test_backpressure();
    rx_hold = 1'b1;
    rx_burst = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      begin
        for (int i = 0; i < 150; i++) send_time(random_time());
      end
    join
    rx_burst = 1'b0;
    wait_drained();
  endtask

  // Random phases under random settings; a few phases with extreme registers.
  task automatic test_random_phases();
    for (int phase_no = 0; phase_no < 12; phase_no++) begin
      case (phase_no % 4)
        0: write_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom());
        1: write_all($urandom_range(0, 32'h0010_0000) - 32'h0008_0000,
                     $urandom_range(0, 32'h0004_0000), $urandom_range(1, 32'h0020_0000),
                     $urandom(), $urandom_range(0, 32'h0200_0000),
                     $urandom_range(0, 32'h0004_0000) - 32'h0002_0000, $urandom());
        2: write_all($urandom(), $urandom_range(0, 16), $urandom_range(1, 200),
                     $urandom(), $urandom_range(0, 3), $urandom_range(0, 8), $urandom());
        default: write_all(32'd0, 32'd65536, 32'd813957, 32'd0, 32'd19353600,
                           $urandom_range(0, 32'h0002_0000), $urandom());
      endcase
      for (int i = 0; i < 100; i++) send_time(random_time());
      if (phase_no % 3 == 0) begin
        rx_burst = 1'b1;
        for (int i = 0; i < 30; i++) send_time(random_time());
        rx_burst = 1'b0;
      end
      wait_drained();
    end
  endtask

  initial begin
    error_count = 0;
    idle_cycles = 0;
    rx_hold = 1'b0;
    rx_burst = 1'b0;
    rst_ni = 1'b0;
    time_ch.valid = 1'b0;
    time_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    result_ch.ready = 1'b0;
    tide_mean = 0;
    tide_amp = 65536;
    tide_period = 813957;
    tide_phase = 0;
    env_period = 0;
    env_range = 0;
    env_phase = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_special_settings();
    test_backpressure();
    test_random_phases();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+sv
sv/htlp_pkg.sv
sv/htlp_chan_if.sv
sv/htlp_delay.sv
sv/htlp_phase_div.sv
sv/htlp_cordic.sv
sv/harmonic_tide_level_predictor_unit.sv
tb/harmonic_tide_level_predictor_unit_tb_if.sv
tb/harmonic_tide_level_predictor_unit_tb.sv
